>>> sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// PSG shared definitions
// Types, constants and table lookups for the tone/noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int CD_W  = 12;
  localparam int TP_W  = 10;
  localparam int EP_W  = 11;
  localparam int VOL_W = 16;
  localparam int ACC_W = 18;
  localparam int SHIFT = 10;
  localparam int CPS_W = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0]       NOISE_CH    = 2'd3;
  localparam logic [14:0]      SR_SEED     = 15'h4000;
  localparam logic [EP_W-1:0]  ZERO_PERIOD = 11'h400;
  localparam logic [CPS_W-1:0] CPS_RESET   = 7'd20;
  localparam logic [EP_W-1:0]  NOISE_RATE0 = 11'h010;
  localparam logic [EP_W-1:0]  NOISE_RATE1 = 11'h020;
  localparam logic [EP_W-1:0]  NOISE_RATE2 = 11'h040;

  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;
  localparam logic [1:0] SIGN_ZERO = 2'b00;

  typedef enum logic [2:0] {
    OP_ATT,
    OP_TONE_LO,
    OP_TONE_HI,
    OP_NOISE,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] ch;
    logic [5:0] val;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_RELOAD,
    ST_MIX,
    ST_EMIT
  } back_state_t;

  function automatic logic [VOL_W-1:0] vol_level(input logic [3:0] att);
    logic [VOL_W-1:0] v;
    case (att)
      4'd0:    v = 16'd32767;
      4'd1:    v = 16'd26028;
      4'd2:    v = 16'd20675;
      4'd3:    v = 16'd16422;
      4'd4:    v = 16'd13045;
      4'd5:    v = 16'd10362;
      4'd6:    v = 16'd8231;
      4'd7:    v = 16'd6538;
      4'd8:    v = 16'd5193;
      4'd9:    v = 16'd4125;
      4'd10:   v = 16'd3277;
      4'd11:   v = 16'd2603;
      4'd12:   v = 16'd2067;
      4'd13:   v = 16'd1642;
      4'd14:   v = 16'd1304;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [EP_W-1:0] eff_period(input logic [TP_W-1:0] p);
    return (p == '0) ? ZERO_PERIOD : {1'b0, p};
  endfunction

  function automatic logic [EP_W-1:0] noise_period(input logic [2:0] mode,
                                                   input logic [TP_W-1:0] tp2);
    logic [EP_W-1:0] r;
    case (mode[1:0])
      2'd0:    r = NOISE_RATE0;
      2'd1:    r = NOISE_RATE1;
      2'd2:    r = NOISE_RATE2;
      default: r = eff_period(tp2);
    endcase
    return r;
  endfunction

endpackage

>>> sv/psg_cmd_if.sv
// ----------------------------------------------------------------------------
// PSG command channel
// Valid/ready channel carrying a command byte write or a sample tick.
// ----------------------------------------------------------------------------
interface psg_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

>>> sv/psg_audio_if.sv
// ----------------------------------------------------------------------------
// PSG audio channel
// Valid/ready channel carrying one signed 8-bit mixed sample.
// ----------------------------------------------------------------------------
interface psg_audio_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> sv/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// PSG tone/noise generator
// Three square-tone channels and one noise channel mixed to 8-bit audio.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   : valid/ready sink. kind 0 writes data_byte as a command byte,
//           kind 1 is a sample tick. Writes produce no output.
//   audio : valid/ready source, one signed sample per tick.
//   cfg_wr_en/cfg_wr_data set clocks per sample; write only while idle.
// Flow:
//   Command transactions pass through a two-entry queue; a write is registered
//   in the queue and takes effect on the edge it leaves the queue. A tick
//   subtracts from and reloads each channel's countdown in turn (one reload
//   per cycle in the shared reload loop), then mixes and emits the sample.
// Reset: volumes silent, periods zero, noise register seeded, queue empty.
// Stall: the sample waits in the output register; the queue keeps taking
//   commands until full, then cmd.ready drops.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator import psg_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CPS_W-1:0] cfg_wr_data,
  psg_cmd_if.sink          cmd,
  psg_audio_if.source      audio
);

  logic [CPS_W-1:0] cps;
  logic             f_valid;
  logic             f_ready;
  op_t              f_op;
  logic             q_valid;
  logic             q_ready;
  op_t              q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cps <= CPS_RESET;
    end else if (cfg_wr_en) begin
      cps <= cfg_wr_data;
    end
  end

  psg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  psg_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  psg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cps      (cps),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (q_op),
    .audio    (audio)
  );

endmodule

>>> sv/psg_front.sv
// ----------------------------------------------------------------------------
// PSG front end
// Accepts command transactions, tracks the latched command and resolves each
// byte into a channel operation for the queue.
// ----------------------------------------------------------------------------
module psg_front import psg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  psg_cmd_if.sink   cmd,
  output logic      op_valid,
  input  logic      op_ready,
  output op_t       op
);

  logic [7:0] latched_command;
  logic [7:0] latch_eff;
  logic [7:0] c;
  logic       accept;

  assign c         = cmd.data_byte;
  assign cmd.ready = op_ready;
  assign op_valid  = cmd.valid;
  assign accept    = cmd.valid && op_ready;
  assign latch_eff = c[7] ? c : latched_command;

  always_comb begin
    op.ch  = latch_eff[6:5];
    op.val = '0;
    if (cmd.kind) begin
      op.kind = OP_TICK;
    end else if (latch_eff[4]) begin
      op.kind = OP_ATT;
      op.val  = {2'b00, c[3:0]};
    end else if (latch_eff[6:5] == NOISE_CH) begin
      op.kind = OP_NOISE;
      op.val  = {3'b000, c[2:0]};
    end else if (c[7]) begin
      op.kind = OP_TONE_LO;
      op.val  = {2'b00, c[3:0]};
    end else begin
      op.kind = OP_TONE_HI;
      op.val  = c[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_command <= '0;
    end else if (accept && !cmd.kind && c[7]) begin
      latched_command <= c;
    end
  end

endmodule

>>> sv/psg_queue.sv
// ----------------------------------------------------------------------------
// PSG operation queue
// Small FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
module psg_queue import psg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/psg_back.sv
// ----------------------------------------------------------------------------
// PSG back end
// Executes register writes and runs the per-tick sequencer: countdown,
// reload loop, noise shifting, mixing, and the output register.
// ----------------------------------------------------------------------------
module psg_back import psg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CPS_W-1:0] cps,
  input  logic             op_valid,
  output logic             op_ready,
  input  op_t              op,
  psg_audio_if.source      audio
);

  back_state_t state, state_next;

  logic signed [CD_W-1:0] countdown [4];
  logic [TP_W-1:0]        tone_period [3];
  logic [2:0]             noise_mode;
  logic [3:0]             attenuation [4];
  logic [1:0]             channel_sign [4];
  logic                   noise_half_phase;
  logic [14:0]            shift_register;
  logic [1:0]             chan;
  logic signed [ACC_W-1:0] acc;
  logic                   out_valid;
  logic signed [7:0]      out_sample;

  logic signed [CD_W-1:0]  cd_cur;
  logic signed [CD_W-1:0]  cd_sub;
  logic [TP_W-1:0]         tp_cur;
  logic [EP_W-1:0]         reload_amt;
  logic                    cd_expired;
  logic                    is_noise;
  logic                    slot_free;
  logic [VOL_W-1:0]        vol;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    mute;
  logic                    sr_fb;
  logic [1:0]              noise_sign;

  assign op_ready     = (state == ST_IDLE);
  assign audio.valid  = out_valid;
  assign audio.sample = out_sample;
  assign slot_free    = !out_valid || audio.ready;

  assign is_noise   = (chan == NOISE_CH);
  assign cd_cur     = countdown[chan];
  assign cd_sub     = cd_cur - $signed({{(CD_W-CPS_W){1'b0}}, cps});
  assign cd_expired = cd_cur[CD_W-1] || (cd_cur == '0);

  always_comb begin
    case (chan)
      2'd0:    tp_cur = tone_period[0];
      2'd1:    tp_cur = tone_period[1];
      2'd2:    tp_cur = tone_period[2];
      default: tp_cur = '0;
    endcase
  end

  assign reload_amt = is_noise ? noise_period(noise_mode, tone_period[2])
                               : eff_period(tp_cur);
  assign mute = (tp_cur != '0) && (tp_cur <= {{(TP_W-CPS_W){1'b0}}, cps});

  always_comb begin
    sr_fb      = shift_register[0];
    noise_sign = channel_sign[NOISE_CH];
    if (noise_mode[2]) begin
      sr_fb = shift_register[0] ^ shift_register[1];
      if (shift_register[0]) begin
        noise_sign = (channel_sign[NOISE_CH] == SIGN_ZERO) ? SIGN_POS
                                                           : -channel_sign[NOISE_CH];
      end
    end else begin
      noise_sign = shift_register[0] ? SIGN_POS : SIGN_ZERO;
    end
  end

  assign vol = vol_level(attenuation[chan]);
  always_comb begin
    case (channel_sign[chan])
      SIGN_POS: term = $signed({{(ACC_W-VOL_W){1'b0}}, vol});
      SIGN_NEG: term = -$signed({{(ACC_W-VOL_W){1'b0}}, vol});
      default:  term = '0;
    endcase
  end
  assign acc_sum = acc + term;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (op_valid && op.kind == OP_TICK) state_next = ST_SUB;
      end
      ST_SUB: begin
        state_next = ST_RELOAD;
      end
      ST_RELOAD: begin
        if (!cd_expired) state_next = is_noise ? ST_MIX : ST_SUB;
      end
      ST_MIX: begin
        if (is_noise) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (audio.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        attenuation[i]  <= 4'hf;
        channel_sign[i] <= SIGN_POS;
      end
      for (int i = 0; i < 3; i++) begin
        countdown[i]   <= '0;
        tone_period[i] <= '0;
      end
      countdown[NOISE_CH] <= CD_W'(1);
      noise_mode       <= '0;
      noise_half_phase <= 1'b1;
      shift_register   <= SR_SEED;
      chan             <= '0;
      acc              <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          chan <= '0;
          acc  <= '0;
          if (op_valid) begin
            case (op.kind)
              OP_ATT: attenuation[op.ch] <= op.val[3:0];
              OP_TONE_LO: begin
                if (op.ch != NOISE_CH) tone_period[op.ch][3:0] <= op.val[3:0];
              end
              OP_TONE_HI: begin
                if (op.ch != NOISE_CH) tone_period[op.ch][9:4] <= op.val;
              end
              OP_NOISE: begin
                noise_mode          <= op.val[2:0];
                shift_register      <= SR_SEED;
                countdown[NOISE_CH] <= $signed({1'b0,
                                         noise_period(op.val[2:0], tone_period[2])});
              end
              default: ;
            endcase
          end
        end
        ST_SUB: begin
          countdown[chan] <= cd_sub;
        end
        ST_RELOAD: begin
          if (cd_expired) begin
            countdown[chan] <= cd_cur + $signed({1'b0, reload_amt});
            if (is_noise) begin
              noise_half_phase <= !noise_half_phase;
              if (!noise_half_phase) begin
                shift_register         <= {sr_fb, shift_register[14:1]};
                channel_sign[NOISE_CH] <= noise_sign;
              end
            end else begin
              channel_sign[chan] <= -channel_sign[chan];
            end
          end else begin
            if (!is_noise) begin
              if (mute) begin
                channel_sign[chan] <= SIGN_ZERO;
              end else if (channel_sign[chan] == SIGN_ZERO) begin
                channel_sign[chan] <= SIGN_POS;
              end
            end
            chan <= chan + 1'b1;
          end
        end
        ST_MIX: begin
          acc  <= acc_sum;
          chan <= chan + 1'b1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_sample <= acc[SHIFT +: 8];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> bench/tb_psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// PSG tone/noise generator testbench
// Feeds command bytes and sample ticks with random gaps on both channels.
// A behavioral copy of the tone, noise and mixer state predicts every mixed
// sample, and each sample is checked against the oldest prediction.
// The clock rate is set at extremes and random values between idle phases.
// ----------------------------------------------------------------------------
module tb_psg_tone_noise_generator;

  localparam bit          KIND_WRITE  = 1'b0;
  localparam bit          KIND_TICK   = 1'b1;
  localparam logic [1:0]  NOISE_IDX   = 2'd3;
  localparam logic [1:0]  RATE_16     = 2'd0;
  localparam logic [1:0]  RATE_32     = 2'd1;
  localparam logic [1:0]  RATE_64     = 2'd2;
  localparam logic [10:0] FULL_PERIOD = 11'h400;
  localparam logic [14:0] LFSR_SEED   = 15'h4000;
  localparam int          SETTLE      = 32;
  localparam int          QUIET_LIMIT = 10000;
  localparam int          MAX_SHOWN   = 10;
  localparam int          LEVELS [16] = '{32767, 26028, 20675, 16422, 13045, 10362,
                                          8231, 6538, 5193, 4125, 3277, 2603,
                                          2067, 1642, 1304, 0};

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [psg_pkg::CPS_W-1:0]   cfg_wr_data;

  psg_cmd_if   cmd_bus ();
  psg_audio_if audio_bus ();

  psg_tone_noise_generator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_bus),
    .audio       (audio_bus)
  );

  always #1 clk = ~clk;

  // predicted chip state
  logic [6:0]         clk_rate;
  logic signed [11:0] countdown [4];
  logic [9:0]         tone_len [3];
  logic [2:0]         noise_mode;
  logic [3:0]         atten [4];
  logic signed [1:0]  polarity [4];
  bit                 noise_phase;
  logic [14:0]        lfsr;
  logic [7:0]         cmd_latch;

  logic signed [7:0]  expected_samples [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 rx_hold_cycles = 0;
  bit                 tx_gaps_on = 1'b1;
  bit                 rx_stalls_on = 1'b1;

  function automatic void reset_chip_state();
    clk_rate = 7'd20;
    for (int i = 0; i < 4; i++) begin
      countdown[i] = '0;
      atten[i] = 4'd15;
      polarity[i] = 2'sd1;
    end
    countdown[NOISE_IDX] = 12'sd1;
    for (int i = 0; i < 3; i++) tone_len[i] = '0;
    noise_mode = '0;
    noise_phase = 1'b1;
    lfsr = LFSR_SEED;
    cmd_latch = '0;
  endfunction

  function automatic logic [10:0] tone_reload(logic [9:0] p);
    return (p == '0) ? FULL_PERIOD : {1'b0, p};
  endfunction

  function automatic logic [10:0] noise_reload();
    case (noise_mode[1:0])
      RATE_16: return 11'h010;
      RATE_32: return 11'h020;
      RATE_64: return 11'h040;
      default: return tone_reload(tone_len[2]);
    endcase
  endfunction

  function automatic void reseed_noise(logic [2:0] mode);
    noise_mode = mode;
    lfsr = LFSR_SEED;
    countdown[NOISE_IDX] = {1'b0, noise_reload()};
  endfunction

  function automatic void apply_command(logic [7:0] c);
    logic [1:0] ch;
    if (c[7]) cmd_latch = c;
    ch = cmd_latch[6:5];
    if (c[7]) begin
      if (c[4]) atten[c[6:5]] = c[3:0];
      else if (c[6:5] == NOISE_IDX) reseed_noise(c[2:0]);
      else tone_len[ch] = {tone_len[ch][9:4], c[3:0]};
    end else if (cmd_latch[4]) begin
      atten[ch] = c[3:0];
    end else if (ch == NOISE_IDX) begin
      reseed_noise(c[2:0]);
    end else begin
      tone_len[ch] = {c[5:0], tone_len[ch][3:0]};
    end
  endfunction

  function automatic void step_lfsr();
    logic fb;
    if (noise_mode[2]) begin
      fb = lfsr[0] ^ lfsr[1];
      if (lfsr[0])
        polarity[NOISE_IDX] = (polarity[NOISE_IDX] == 0) ? 2'sd1 : -polarity[NOISE_IDX];
    end else begin
      fb = lfsr[0];
      polarity[NOISE_IDX] = lfsr[0] ? 2'sd1 : 2'sd0;
    end
    lfsr = {fb, lfsr[14:1]};
  endfunction

  function automatic logic signed [7:0] mix_next_sample();
    int c;
    int sum;
    for (int i = 0; i < 3; i++) begin
      c = int'(countdown[i]) - int'(clk_rate);
      while (c <= 0) begin
        c += int'(tone_reload(tone_len[i]));
        polarity[i] = -polarity[i];
      end
      countdown[i] = c[11:0];
      if (tone_len[i] != 0 && tone_len[i] <= clk_rate) polarity[i] = 2'sd0;
      else if (polarity[i] == 0) polarity[i] = 2'sd1;
    end
    c = int'(countdown[NOISE_IDX]) - int'(clk_rate);
    while (c <= 0) begin
      c += int'(noise_reload());
      noise_phase = !noise_phase;
      if (noise_phase) step_lfsr();
    end
    countdown[NOISE_IDX] = c[11:0];
    sum = 0;
    for (int i = 0; i < 4; i++) sum += int'(polarity[i]) * LEVELS[atten[i]];
    sum = sum >>> 10;
    return sum[7:0];
  endfunction

  function automatic logic [7:0] random_command();
    case ($urandom_range(9, 0))
      0, 1:    return {1'b1, 2'($urandom_range(2, 0)), 1'b0, 4'($urandom)};
      2, 3:    return {1'b0, 7'($urandom)};
      4:       return {1'b1, 2'($urandom), 1'b1, 4'($urandom)};
      5:       return {3'b111, 1'b0, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input bit kind, input logic [7:0] data);
    int gap;
    gap = tx_gaps_on ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.kind <= kind;
    cmd_bus.data_byte <= data;
    do @(posedge clk); while (!cmd_bus.ready);
    if (kind == KIND_TICK) expected_samples.push_back(mix_next_sample());
    else apply_command(data);
  endtask

  task automatic wait_for_samples();
    cmd_bus.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rate(input logic [6:0] rate);
    wait_for_samples();
    cfg_wr_data <= rate;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clk_rate = rate;
  endtask

  task automatic send_writes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_item(KIND_WRITE, bytes[i]);
  endtask

  task automatic test_reset_state();
    send_item(KIND_TICK, 8'h00);
  endtask

  // white and periodic modes, latched and data-byte noise writes
  task automatic test_noise_writes();
    send_writes('{8'hE4, 8'hF0});
    send_item(KIND_TICK, 8'hFF);
    send_writes('{8'hE0, 8'h07});
    send_item(KIND_TICK, 8'h00);
    send_writes('{8'hE3, 8'hFF});
    send_item(KIND_TICK, 8'h5A);
  endtask

  // period halves, zero period, muted high tone, attenuation by data byte
  task automatic test_tone_writes();
    send_writes('{8'h90, 8'h80, 8'h3F, 8'h8F});
    send_item(KIND_TICK, 8'h00);
    send_writes('{8'hB5, 8'h00, 8'hA1, 8'hC0, 8'h7F});
    send_item(KIND_TICK, 8'hA5);
  endtask

  task automatic test_rate_extremes();
    logic [6:0] rates [4] = '{7'd127, 7'd0, 7'd1, 7'd64};
    foreach (rates[i]) begin
      set_rate(rates[i]);
      send_item(KIND_TICK, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] rate;
    for (int phase = 0; phase < 8; phase++) begin
      rate = (phase == 0) ? 7'd1 : (phase == 1) ? 7'd64 : 7'($urandom_range(64, 1));
      set_rate(rate);
      tx_gaps_on = ($urandom_range(3, 0) != 0);
      rx_stalls_on = ($urandom_range(3, 0) != 0);
      repeat (200) begin
        if ($urandom_range(99, 0) < 45) send_item(KIND_TICK, 8'($urandom));
        else send_item(KIND_WRITE, random_command());
      end
    end
  endtask

  task automatic test_backpressure();
    set_rate(7'($urandom_range(64, 1)));
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_item(KIND_TICK, 8'($urandom));
      else send_item(KIND_WRITE, random_command());
    end
    wait_for_samples();
    tx_gaps_on = 1'b1;
  endtask

  function automatic void check_sample(logic signed [7:0] got);
    logic signed [7:0] want;
    if (expected_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("unexpected sample %0d, none pending", got);
    end else begin
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("sample mismatch: expected %0d, got %0d", want, got);
      end
    end
  endfunction

  initial begin : sample_sink
    int stall;
    audio_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_stalls_on ? $urandom_range(13, 0) : 0;
      if (rx_hold_cycles > 0) begin
        stall += rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        audio_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      audio_bus.ready <= 1'b1;
      do @(posedge clk); while (!audio_bus.valid);
      check_sample(audio_bus.sample);
    end
  end

  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (audio_bus.valid && audio_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.kind <= KIND_WRITE;
    cmd_bus.data_byte <= '0;
    reset_chip_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_noise_writes();
    test_tone_writes();
    test_rate_extremes();
    test_random_traffic();
    test_backpressure();

    wait_for_samples();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/psg_pkg.sv
sv/psg_cmd_if.sv
sv/psg_audio_if.sv
sv/psg_front.sv
sv/psg_queue.sv
sv/psg_back.sv
sv/psg_tone_noise_generator.sv
bench/tb_psg_tone_noise_generator.sv
